>>> hw/rtl/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants for the RGB color filter
// Pixel request/result structs, filter mode codes and the fixed-point
// coefficients used by the grayscale and sepia weighted sums.
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int COORD_W = 10;
  localparam int CH_W    = 8;
  localparam int MODE_W  = 3;

  // Configuration port geometry: one 32-bit register per word
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE = '0;

  // Filter mode codes; the unused code falls back to identity
  localparam logic [MODE_W-1:0] MODE_IDENT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RED   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GREEN = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BLUE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GRAY  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SEPIA = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NEG   = 3'd6;

  localparam logic [CH_W-1:0] CH_MAX = '1;

  // floor(n / 10000) == (n * RECIP_M) >> RECIP_SHIFT for every n below 2^21,
  // which covers any 8-bit channel times a coefficient in ten-thousandths.
  localparam int          RECIP_SHIFT = 35;
  localparam int          CONST_W     = RECIP_SHIFT;
  localparam logic [63:0] RECIP_M     = ((64'd1 << RECIP_SHIFT) + 64'd9999) / 64'd10000;

  // Coefficient in ten-thousandths folded with the reciprocal
  function automatic logic [CONST_W-1:0] fold_coef(input logic [63:0] k);
    logic [63:0] c;
    c = k * RECIP_M;
    return c[CONST_W-1:0];
  endfunction

  localparam logic [CONST_W-1:0] GRAY_CR  = fold_coef(64'd2986);
  localparam logic [CONST_W-1:0] GRAY_CG  = fold_coef(64'd5870);
  localparam logic [CONST_W-1:0] GRAY_CB  = fold_coef(64'd1140);
  localparam logic [CONST_W-1:0] SEP_R_CR = fold_coef(64'd3930);
  localparam logic [CONST_W-1:0] SEP_R_CG = fold_coef(64'd7690);
  localparam logic [CONST_W-1:0] SEP_R_CB = fold_coef(64'd1890);
  localparam logic [CONST_W-1:0] SEP_G_CR = fold_coef(64'd3490);
  localparam logic [CONST_W-1:0] SEP_G_CG = fold_coef(64'd6860);
  localparam logic [CONST_W-1:0] SEP_G_CB = fold_coef(64'd1680);
  localparam logic [CONST_W-1:0] SEP_B_CR = fold_coef(64'd2720);
  localparam logic [CONST_W-1:0] SEP_B_CG = fold_coef(64'd5340);
  localparam logic [CONST_W-1:0] SEP_B_CB = fold_coef(64'd1310);

  typedef struct packed {
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [CH_W-1:0]    red_in;
    logic [CH_W-1:0]    green_in;
    logic [CH_W-1:0]    blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_out;
    logic [COORD_W-1:0] y_out;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
  } pix_out_t;

  // One floored term: floor(p * k / 10000) with k pre-folded
  function automatic logic [CH_W-1:0] scale_term(input logic [CH_W-1:0]    p,
                                                 input logic [CONST_W-1:0] c);
    logic [CH_W+CONST_W-1:0] prod;
    prod = {{CONST_W{1'b0}}, p} * {{CH_W{1'b0}}, c};
    return prod[RECIP_SHIFT +: CH_W];
  endfunction

  // Sum of three floored terms, saturated to the channel range
  function automatic logic [CH_W-1:0] weighted_sum(input logic [CH_W-1:0]    r,
                                                   input logic [CH_W-1:0]    g,
                                                   input logic [CH_W-1:0]    b,
                                                   input logic [CONST_W-1:0] cr,
                                                   input logic [CONST_W-1:0] cg,
                                                   input logic [CONST_W-1:0] cb);
    logic [CH_W+1:0] s;
    s = {2'b00, scale_term(r, cr)} + {2'b00, scale_term(g, cg)}
      + {2'b00, scale_term(b, cb)};
    return (s[CH_W+1:CH_W] != 2'b00) ? CH_MAX : s[CH_W-1:0];
  endfunction

endpackage

>>> hw/rtl/rcf_regs.sv
// ----------------------------------------------------------------------------
// rcf_regs: configuration register file
// APB-style slave holding the filter mode register; zero wait states.
// ----------------------------------------------------------------------------
module rcf_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rcf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rcf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [rcf_pkg::MODE_W-1:0]      filter_mode
);
  import rcf_pkg::*;

  logic [MODE_W-1:0]    mode_r;
  logic [MODE_W-1:0]    mode_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Take the low mode bits on a write to the mode register, drop others
  always_comb begin
    mode_nxt = mode_r;
    if (wr_en && (reg_idx == REG_FILTER_MODE)) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDENT;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // Read back the mode register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_FILTER_MODE) begin
      prdata = {{(CFG_DATA_W-MODE_W){1'b0}}, mode_r};
    end
  end

  assign filter_mode = mode_r;

endmodule

>>> hw/rtl/rcf_filter.sv
// ----------------------------------------------------------------------------
// rcf_filter: per-pixel color transform
// Combinational datapath selecting one of seven filters by mode; passes the
// coordinates through untouched.
// ----------------------------------------------------------------------------
module rcf_filter (
  input  logic [rcf_pkg::MODE_W-1:0] filter_mode,
  input  rcf_pkg::pix_in_t           pix_in,
  output rcf_pkg::pix_out_t          pix_out
);
  import rcf_pkg::*;

  logic [CH_W-1:0] r;
  logic [CH_W-1:0] g;
  logic [CH_W-1:0] b;
  logic [CH_W-1:0] gray;
  logic [CH_W-1:0] sep_r;
  logic [CH_W-1:0] sep_g;
  logic [CH_W-1:0] sep_b;

  assign r = pix_in.red_in;
  assign g = pix_in.green_in;
  assign b = pix_in.blue_in;

  // Constant-coefficient weighted sums
  assign gray  = weighted_sum(r, g, b, GRAY_CR, GRAY_CG, GRAY_CB);
  assign sep_r = weighted_sum(r, g, b, SEP_R_CR, SEP_R_CG, SEP_R_CB);
  assign sep_g = weighted_sum(r, g, b, SEP_G_CR, SEP_G_CG, SEP_G_CB);
  assign sep_b = weighted_sum(r, g, b, SEP_B_CR, SEP_B_CG, SEP_B_CB);

  // Select the filter output
  always_comb begin
    pix_out.x_out = pix_in.x_coord;
    pix_out.y_out = pix_in.y_coord;
    unique case (filter_mode)
      MODE_RED: begin
        pix_out.red_out   = r;
        pix_out.green_out = '0;
        pix_out.blue_out  = '0;
      end
      MODE_GREEN: begin
        pix_out.red_out   = '0;
        pix_out.green_out = g;
        pix_out.blue_out  = '0;
      end
      MODE_BLUE: begin
        pix_out.red_out   = '0;
        pix_out.green_out = '0;
        pix_out.blue_out  = b;
      end
      MODE_GRAY: begin
        pix_out.red_out   = gray;
        pix_out.green_out = gray;
        pix_out.blue_out  = gray;
      end
      MODE_SEPIA: begin
        pix_out.red_out   = sep_r;
        pix_out.green_out = sep_g;
        pix_out.blue_out  = sep_b;
      end
      MODE_NEG: begin
        pix_out.red_out   = CH_MAX - r;
        pix_out.green_out = CH_MAX - g;
        pix_out.blue_out  = CH_MAX - b;
      end
      default: begin
        // identity, and the unused code
        pix_out.red_out   = r;
        pix_out.green_out = g;
        pix_out.blue_out  = b;
      end
    endcase
  end

endmodule

>>> hw/rtl/rgb_color_filter.sv
// ----------------------------------------------------------------------------
// rgb_color_filter: streaming RGB pixel filter
// Identity, single channel, grayscale, sepia or negative per pixel, chosen
// by the filter mode register; coordinates pass through.
//
//   channel   direction  handshake            payload
//   in_       sink       in_valid / in_stall  pix_in_t  (x, y, r, g, b)
//   out_      source     out_valid/out_stall  pix_out_t (x, y, r, g, b)
//   config    APB slave  psel/penable/pready  filter_mode at byte address 0
//
// One pixel per clock while out_stall stays low; each pixel passes the input
// register then the result register, with the filter logic between them.
// The input register frees up whenever the result register moves, and when
// empty it takes a new request while a finished result waits on out_stall.
// in_stall rises only when both registers are full and the output is stalled.
// Synchronous active-low reset empties both registers and sets identity mode.
// ----------------------------------------------------------------------------
module rgb_color_filter #(
  parameter int COORD_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rcf_pkg::pix_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rcf_pkg::pix_out_t               out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rcf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rcf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rcf_pkg::*;

  localparam int KEEP_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << KEEP_BITS) - 64'd1);

  logic [MODE_W-1:0] filter_mode;
  logic              s1_vld_r;
  logic              s1_vld_nxt;
  pix_in_t           s1_data_r;
  pix_in_t           in_trim;
  logic              out_vld_r;
  logic              out_vld_nxt;
  pix_out_t          out_data_r;
  pix_out_t          filt_pix;
  logic              out_adv;
  logic              s1_adv;
  logic              in_acc;

  rcf_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .filter_mode (filter_mode)
  );

  rcf_filter u_filter (
    .filter_mode (filter_mode),
    .pix_in      (s1_data_r),
    .pix_out     (filt_pix)
  );

  // Pipeline advance: result register loads when empty or being taken
  assign out_adv  = !out_vld_r || !out_stall;
  assign s1_adv   = !s1_vld_r || out_adv;
  assign in_stall = !s1_adv;
  assign in_acc   = in_valid && s1_adv;

  always_comb begin
    s1_vld_nxt  = s1_adv ? in_valid : s1_vld_r;
    out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Trim coordinates to the configured width
  always_comb begin
    in_trim         = in_data;
    in_trim.x_coord = in_data.x_coord & COORD_MASK;
    in_trim.y_coord = in_data.y_coord & COORD_MASK;
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_trim;
    end
  end

  // Hold the filtered result until it is taken
  always_ff @(posedge clk) begin
    if (out_adv && s1_vld_r) begin
      out_data_r <= filt_pix;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Back-pressure only when both registers hold a request
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("in_stall raised with room in the pipeline");

  // A buffered request reaches the output once the output frees up
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !(out_vld_r && out_stall)) |=> out_vld_r)
    else $error("buffered request lost on its way to the output");

  // A stalled result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> (out_vld_r && $stable(out_data_r)))
    else $error("stalled result changed");

  // Grayscale results carry one value on all three channels
  a_gray_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (filter_mode == MODE_GRAY)) |->
      ((out_data_r.red_out == out_data_r.green_out) &&
       (out_data_r.green_out == out_data_r.blue_out)))
    else $error("grayscale channels differ");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !s1_vld_r))
    else $error("pipeline not empty after reset");

endmodule
